/* sv/dobc_pkg.sv */
package dobc_pkg;

	localparam int unsigned TIME_BITS_DEF = 16;
	localparam int unsigned COUNT_BITS    = 16;
	localparam logic [COUNT_BITS-1:0] BLINK_FOREVER = '1;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_ON    = 2'd1;
	localparam logic [1:0] FUNC_OFF   = 2'd2;
	localparam logic [1:0] FUNC_BLINK = 2'd3;

	typedef struct packed {
		logic [1:0]            func;
		logic [15:0]           on_ticks;
		logic [15:0]           off_ticks;
		logic [COUNT_BITS-1:0] cycle_count;
	} in_item_t;

	typedef struct packed {
		logic pin_level;
		logic logical_on;
		logic blinking;
	} out_item_t;

endpackage

/* sv/dobc_core.sv */
module dobc_core import dobc_pkg::*; #(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	input  logic      idle_level,
	output out_item_t result
);

	logic                  on_q, on_d;
	logic                  blink_q, blink_d;
	logic [TIME_BITS-1:0]  phase_q, phase_d;
	logic [TIME_BITS-1:0]  on_len_q, on_len_d;
	logic [TIME_BITS-1:0]  off_len_q, off_len_d;
	logic [COUNT_BITS-1:0] cycles_q, cycles_d;
	logic [TIME_BITS-1:0]  phase_inc;
	logic [COUNT_BITS-1:0] cycles_dec;

	assign phase_inc  = phase_q + TIME_BITS'(1);
	assign cycles_dec = (cycles_q == BLINK_FOREVER) ? cycles_q : cycles_q - COUNT_BITS'(1);

	always_comb begin
		on_d      = on_q;
		blink_d   = blink_q;
		phase_d   = phase_q;
		on_len_d  = on_len_q;
		off_len_d = off_len_q;
		cycles_d  = cycles_q;
		case (item.func)
			FUNC_TICK: begin
				if (blink_q) begin
					phase_d = phase_inc;
					if (on_q) begin
						if (phase_inc >= on_len_q) begin
							phase_d = '0;
							on_d    = 1'b0;
						end
					end else if (phase_inc >= off_len_q) begin
						// end of an off phase closes one cycle
						phase_d  = '0;
						cycles_d = cycles_dec;
						if (cycles_dec == '0) begin
							blink_d = 1'b0;
							on_d    = 1'b0;
						end else begin
							on_d = 1'b1;
						end
					end
				end
			end
			FUNC_ON: begin
				blink_d = 1'b0;
				on_d    = 1'b1;
			end
			FUNC_OFF: begin
				blink_d = 1'b0;
				on_d    = 1'b0;
			end
			FUNC_BLINK: begin
				// zero count leaves everything alone
				if (item.cycle_count != '0) begin
					on_len_d  = TIME_BITS'(item.on_ticks);
					off_len_d = TIME_BITS'(item.off_ticks);
					cycles_d  = item.cycle_count;
					blink_d   = 1'b1;
					on_d      = 1'b1;
					phase_d   = '0;
				end
			end
			default: begin
				on_d = on_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q      <= 1'b0;
			blink_q   <= 1'b0;
			phase_q   <= '0;
			on_len_q  <= '0;
			off_len_q <= '0;
			cycles_q  <= '0;
		end else if (accept) begin
			on_q      <= on_d;
			blink_q   <= blink_d;
			phase_q   <= phase_d;
			on_len_q  <= on_len_d;
			off_len_q <= off_len_d;
			cycles_q  <= cycles_d;
		end
	end

	assign result.pin_level  = on_d ^ idle_level;
	assign result.logical_on = on_d;
	assign result.blinking   = blink_d;

endmodule

/* sv/dobc_out_buf.sv */
module dobc_out_buf import dobc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic      main_v_q;
	logic      skid_v_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      main_free;

	assign main_free = !main_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : push_item;
		end else if (push) begin
			// head is held, park the new result behind it
			skid_q <= push_item;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_item  = main_q;

endmodule

/* sv/digital_output_blink_controller.sv */
// One digital output pin (LED, buzzer, relay) with steady and blink control.
// Input channel: in_valid / in_stall with in_item carrying func (tick, on,
// off, blink) and the blink on/off phase lengths and cycle count.
// Output channel: out_valid / out_stall with out_item giving the pin level,
// the logical on flag and the blinking flag after each item.
// Every accepted input produces exactly one result, in order.
// Each result is registered in the output register, or in the skid entry
// behind a held one. Throughput is one item per cycle while out_stall is low.
// A two-entry output buffer lets one more item in while a result is held;
// in_stall rises only when both entries are occupied.
// cfg_we / cfg_wdata write idle_level, the pin level while the output is off.
// Write it only while no results are outstanding.
// Reset clears the output state (off, not blinking), the phase counters
// and idle_level, and empties the output buffer.
module digital_output_blink_controller import dobc_pkg::*; #(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	logic      idle_level_q;
	logic      accept;
	logic      buf_full;
	out_item_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q <= 1'b0;
		end else if (cfg_we) begin
			idle_level_q <= cfg_wdata;
		end
	end

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	dobc_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_item),
		.idle_level(idle_level_q),
		.result    (result)
	);

	dobc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(result),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// skid entry only fills behind a held head
	a_stall_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	a_transfer_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted item produced no result");

	a_pin_polarity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_we && !$past(cfg_we)) |->
		(out_item.pin_level == (out_item.logical_on ^ idle_level_q)))
		else $error("pin level does not match on flag and polarity");

endmodule

/* test/tb_digital_output_blink_controller.sv */
`timescale 1ns / 1ps

module tb_digital_output_blink_controller;
	import dobc_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      cfg_we;
	logic      cfg_wdata;

	// own copy of the pin state
	logic                     m_idle    = 1'b0;
	logic                     m_on      = 1'b0;
	logic                     m_blink   = 1'b0;
	logic [TIME_BITS_DEF-1:0] m_phase   = '0;
	logic [TIME_BITS_DEF-1:0] m_on_len  = '0;
	logic [TIME_BITS_DEF-1:0] m_off_len = '0;
	logic [COUNT_BITS-1:0]    m_left    = '0;

	out_item_t pin_states_due[$];
	int        n_fail        = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        hold_left     = 0;

	digital_output_blink_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic step_pin_model(input in_item_t it, output out_item_t r);
		case (it.func)
			FUNC_TICK: begin
				if (m_blink) begin
					m_phase = m_phase + TIME_BITS_DEF'(1);
					if (m_on) begin
						if (m_phase >= m_on_len) begin
							m_phase = '0;
							m_on    = 1'b0;
						end
					end else if (m_phase >= m_off_len) begin
						m_phase = '0;
						if (m_left != BLINK_FOREVER)
							m_left = m_left - COUNT_BITS'(1);
						if (m_left == '0) begin
							m_blink = 1'b0;
							m_on    = 1'b0;
						end else begin
							m_on = 1'b1;
						end
					end
				end
			end
			FUNC_ON: begin
				m_blink = 1'b0;
				m_on    = 1'b1;
			end
			FUNC_OFF: begin
				m_blink = 1'b0;
				m_on    = 1'b0;
			end
			FUNC_BLINK: begin
				// zero count leaves everything alone
				if (it.cycle_count != '0) begin
					m_on_len  = it.on_ticks;
					m_off_len = it.off_ticks;
					m_left    = it.cycle_count;
					m_blink   = 1'b1;
					m_on      = 1'b1;
					m_phase   = '0;
				end
			end
			default: begin
				m_on = m_on;
			end
		endcase
		r.pin_level  = m_on ^ m_idle;
		r.logical_on = m_on;
		r.blinking   = m_blink;
	endtask

	// transfers are sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		out_item_t fresh;
		out_item_t oldest;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_pin_model(in_item, fresh);
				pin_states_due.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				if (pin_states_due.size() == 0) begin
					$error("result with nothing expected: %b", out_item);
					n_fail++;
				end else begin
					oldest = pin_states_due.pop_front();
					if (out_item.pin_level !== oldest.pin_level) begin
						$error("pin_level: expected %0b, got %0b",
							oldest.pin_level, out_item.pin_level);
						n_fail++;
					end
					if (out_item.logical_on !== oldest.logical_on) begin
						$error("logical_on: expected %0b, got %0b",
							oldest.logical_on, out_item.logical_on);
						n_fail++;
					end
					if (out_item.blinking !== oldest.blinking) begin
						$error("blinking: expected %0b, got %0b",
							oldest.blinking, out_item.blinking);
						n_fail++;
					end
				end
			end
		end
	end

	// receiver: random stall, or a long hold-off when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	function automatic in_item_t make_item(input logic [1:0] f);
		in_item_t it;
		it.func        = f;
		it.on_ticks    = 16'($urandom);
		it.off_ticks   = 16'($urandom);
		it.cycle_count = COUNT_BITS'($urandom);
		return it;
	endfunction

	function automatic in_item_t blink_cmd(input logic [15:0] on_t, input logic [15:0] off_t,
		input logic [COUNT_BITS-1:0] count);
		in_item_t it;
		it.func        = FUNC_BLINK;
		it.on_ticks    = on_t;
		it.off_ticks   = off_t;
		it.cycle_count = count;
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic offer_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item  = it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic offer_ticks(input int n);
		repeat (n)
			offer_item(make_item(FUNC_TICK));
	endtask

	task automatic wait_all_results;
		in_valid = 1'b0;
		while (pin_states_due.size() != 0)
			@(negedge clk);
		repeat (3)
			@(negedge clk);
	endtask

	task automatic set_idle_level(input logic v);
		wait_all_results();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		m_idle = v;
	endtask

	task automatic test_idle_ticks;
		offer_ticks(2);
	endtask

	task automatic test_steady_commands;
		offer_item(make_item(FUNC_ON));
		offer_ticks(1);
		offer_item(blink_cmd(16'd3, 16'd3, '0));
		offer_item(make_item(FUNC_OFF));
		offer_ticks(1);
	endtask

	task automatic test_blink_basics;
		// zero length phases end on their first tick
		offer_item(blink_cmd(16'd0, 16'd0, 16'd1));
		offer_ticks(2);
		offer_item(blink_cmd(16'd1, 16'd2, 16'd2));
		offer_ticks(6);
		offer_item(blink_cmd(16'd0, 16'd0, BLINK_FOREVER));
		offer_ticks(2);
		offer_item(make_item(FUNC_ON));
	endtask

	task automatic test_extremes;
		offer_item(blink_cmd(16'hFFFF, 16'hFFFF, BLINK_FOREVER));
		offer_ticks(1);
		offer_item(make_item(FUNC_OFF));
		offer_item(blink_cmd(16'h0000, 16'hFFFF, 16'd1));
		offer_ticks(2);
	endtask

	task automatic test_polarity;
		set_idle_level(1'b1);
		offer_item(make_item(FUNC_ON));
		offer_item(make_item(FUNC_OFF));
		set_idle_level(1'b0);
		offer_item(make_item(FUNC_OFF));
	endtask

	task automatic test_random_traffic(input int n_items);
		int       sent;
		int       ticks;
		int       pick;
		in_item_t it;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// short blink run followed by ticks
				it = blink_cmd(16'($urandom_range(4)), 16'($urandom_range(4)), 16'd1);
				case ($urandom_range(9))
					0:       it.cycle_count = BLINK_FOREVER;
					1:       it.cycle_count = '0;
					2:       it.cycle_count = BLINK_FOREVER - COUNT_BITS'(1);
					default: it.cycle_count = COUNT_BITS'($urandom_range(1, 3));
				endcase
				offer_item(it);
				sent++;
				ticks = $urandom_range(2, 24);
				repeat (ticks) begin
					if ($urandom_range(19) == 0)
						offer_item(make_item(2'($urandom_range(1, 3))));
					else
						offer_item(make_item(FUNC_TICK));
					sent++;
				end
			end else if (pick < 80) begin
				offer_item(make_item(FUNC_BLINK));
				sent++;
			end else begin
				offer_item(make_item(2'($urandom_range(3))));
				sent++;
			end
		end
	endtask

	task automatic test_backpressure;
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = HOLD_CYCLES;
		offer_item(blink_cmd(16'd2, 16'd1, 16'd3));
		for (i = 0; i < 30; i++)
			offer_item(make_item(FUNC_TICK));
		// sender waits for every outstanding result
		wait_all_results();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_ticks();
		test_steady_commands();
		test_blink_basics();
		test_extremes();
		test_polarity();

		set_idle_level(1'b1);
		send_idle_pct = 30;
		recv_idle_pct = 66;
		test_random_traffic(200);

		set_idle_level(1'b0);
		send_idle_pct = 66;
		recv_idle_pct = 30;
		test_random_traffic(200);

		set_idle_level(1'b1);
		test_backpressure();

		set_idle_level(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(200);

		wait_all_results();
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
